// File: design/anfp_pkg.sv
// package for the ascii numeric field parser: codes, character constants, scale helper
package anfp_pkg;

  localparam int PRICE_DECIMALS_DEF = 4;
  localparam int VALUE_W            = 64;
  localparam int SCALE_W            = 32;  // holds 10**9

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_ACC,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_UNSIGNED = 2'd0,
    KIND_SIGNED   = 2'd1,
    KIND_PRICE    = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // powers of ten up to 10**9, only called with constant arguments
  function automatic logic [SCALE_W-1:0] pow10(input int n);
    logic [SCALE_W-1:0] r;
    r = SCALE_W'(1);
    for (int i = 0; i < 9; i++) begin
      if (i < n) begin
        r = SCALE_W'(r * SCALE_W'(10));
      end
    end
    return r;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_BAR) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_HASH);
  endfunction

endpackage

// File: design/ascii_numeric_field_parser.sv
// top level: byte-serial ascii decimal field parser with registered result stage
//
// The parser takes one message byte per clock while in_tready is high and updates
// its field state in the same cycle; a field result is written to the output stage on the
// byte that ends the field (delimiter, end of message or a bad character).
// Per-byte work is one shift-add step of three 64-bit accumulators (plain,
// negated and price-scaled), so no multiply is needed when a field closes.
// Results sit in a two-entry output stage (output register plus skid entry),
// so input beats keep flowing while one result waits; in_tready drops only
// when both entries are full. Sustained rate is one byte per cycle while in_tready is high.
module ascii_numeric_field_parser #(
  parameter int PRICE_DECIMALS = anfp_pkg::PRICE_DECIMALS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] field_value
  output logic [1:0]  out_tuser   // [0] bad_character, [1] decimals_exceeded
);
  import anfp_pkg::*;

  localparam int DEC_W = $clog2(PRICE_DECIMALS + 2);
  localparam logic [DEC_W-1:0] DEC_MAX = DEC_W'(PRICE_DECIMALS);
  localparam logic [SCALE_W-1:0] INT_SCALE = pow10(PRICE_DECIMALS);

  // field state
  phase_t               phase_r, phase_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic [VALUE_W-1:0]   nacc_r, nacc_nxt;
  logic [VALUE_W-1:0]   sacc_r, sacc_nxt;
  logic                 minus_r, minus_nxt;
  logic                 first_r, first_nxt;
  logic                 point_r, point_nxt;
  logic [DEC_W-1:0]     dec_r, dec_nxt;
  logic [1:0]           kind_r, kind_nxt;

  // output stage
  logic                 ov_r, ov_nxt;
  logic                 sv_r, sv_nxt;
  logic [VALUE_W-1:0]   oval_r, oval_nxt, sval_r, sval_nxt;
  logic [1:0]           oflg_r, oflg_nxt, sflg_r, sflg_nxt;

  logic                 in_beat, pop;
  logic [7:0]           c;
  logic                 delim, digit_ok;
  logic [3:0]           digit;

  // working copy of the field (cleared when a new field opens)
  logic [VALUE_W-1:0]   w_acc, w_nacc, w_sacc;
  logic                 w_minus, w_first, w_point;
  logic [DEC_W-1:0]     w_dec;
  logic [1:0]           w_kind;

  logic [SCALE_W-1:0]   dscale;
  logic [SCALE_W+3:0]   dprod;

  logic                 emit;
  logic [VALUE_W-1:0]   res_val;
  logic [1:0]           res_flg;

  assign in_tready = !sv_r;
  assign in_beat   = in_tvalid && in_tready;
  assign pop       = ov_r && out_tready;
  assign c         = in_tdata;
  assign delim     = is_delim(c);
  assign digit_ok  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit     = 4'(c - CH_ZERO);

  always_comb begin
    if (phase_r == PH_ACC) begin
      w_acc   = acc_r;
      w_nacc  = nacc_r;
      w_sacc  = sacc_r;
      w_minus = minus_r;
      w_first = first_r;
      w_point = point_r;
      w_dec   = dec_r;
      w_kind  = kind_r;
    end else begin
      w_acc   = '0;
      w_nacc  = '0;
      w_sacc  = '0;
      w_minus = 1'b0;
      w_first = 1'b0;
      w_point = 1'b0;
      w_dec   = '0;
      w_kind  = in_tuser;
    end
  end

  // digit weight for the scaled accumulator
  always_comb begin
    dscale = '0;
    if (!w_point) begin
      dscale = INT_SCALE;
    end else begin
      for (int i = 0; i < PRICE_DECIMALS; i++) begin
        if (w_dec == DEC_W'(i)) begin
          dscale = pow10(PRICE_DECIMALS - 1 - i);
        end
      end
    end
  end

  assign dprod = (SCALE_W + 4)'(digit) * (SCALE_W + 4)'(dscale);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    nacc_nxt  = nacc_r;
    sacc_nxt  = sacc_r;
    minus_nxt = minus_r;
    first_nxt = first_r;
    point_nxt = point_r;
    dec_nxt   = dec_r;
    kind_nxt  = kind_r;
    emit      = 1'b0;
    res_val   = '0;
    res_flg   = 2'b00;

    if (in_beat) begin
      unique case (phase_r)
        PH_DISCARD: begin
          if (delim || in_tlast) begin
            phase_nxt = PH_SKIP;
            acc_nxt   = '0;
            nacc_nxt  = '0;
            sacc_nxt  = '0;
            minus_nxt = 1'b0;
            first_nxt = 1'b0;
            point_nxt = 1'b0;
            dec_nxt   = '0;
          end
        end
        PH_SKIP, PH_ACC: begin
          if (phase_r == PH_SKIP && c == CH_SPACE) begin
            // message ends inside leading spaces: empty field
            if (in_tlast) begin
              kind_nxt = in_tuser;
              emit     = 1'b1;
            end
          end else begin
            acc_nxt   = w_acc;
            nacc_nxt  = w_nacc;
            sacc_nxt  = w_sacc;
            minus_nxt = w_minus;
            first_nxt = w_first;
            point_nxt = w_point;
            dec_nxt   = w_dec;
            kind_nxt  = w_kind;
            phase_nxt = PH_ACC;

            if (!delim) begin
              first_nxt = 1'b1;
              if (w_kind == KIND_SIGNED && !w_first && c == CH_MINUS) begin
                minus_nxt = 1'b1;
              end else if (w_kind == KIND_PRICE && c == CH_POINT && !w_point) begin
                point_nxt = 1'b1;
              end else if (digit_ok) begin
                acc_nxt  = (w_acc << 3) + (w_acc << 1) + VALUE_W'(digit);
                nacc_nxt = (w_nacc << 3) + (w_nacc << 1) - VALUE_W'(digit);
                sacc_nxt = (w_point ? w_sacc : (w_sacc << 3) + (w_sacc << 1)) +
                           VALUE_W'(dprod);
                if (w_kind == KIND_PRICE && w_point && w_dec <= DEC_MAX) begin
                  dec_nxt = w_dec + DEC_W'(1);
                end
              end else begin
                emit      = 1'b1;
                res_flg   = 2'b01;
                phase_nxt = in_tlast ? PH_SKIP : PH_DISCARD;
              end
            end

            if (!emit && (delim || in_tlast)) begin
              emit      = 1'b1;
              phase_nxt = PH_SKIP;
              if (w_kind == KIND_SIGNED) begin
                res_val = minus_nxt ? nacc_nxt : acc_nxt;
              end else if (w_kind == KIND_PRICE) begin
                if (dec_nxt > DEC_MAX) begin
                  res_flg = 2'b10;
                end else begin
                  res_val = sacc_nxt;
                end
              end else begin
                res_val = acc_nxt;
              end
            end

            if (emit) begin
              acc_nxt   = '0;
              nacc_nxt  = '0;
              sacc_nxt  = '0;
              minus_nxt = 1'b0;
              first_nxt = 1'b0;
              point_nxt = 1'b0;
              dec_nxt   = '0;
            end
          end
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end
  end

  // two-entry output stage: skid entry fills only while the output waits
  always_comb begin
    ov_nxt   = ov_r;
    sv_nxt   = sv_r;
    oval_nxt = oval_r;
    oflg_nxt = oflg_r;
    sval_nxt = sval_r;
    sflg_nxt = sflg_r;
    if (sv_r) begin
      if (pop) begin
        oval_nxt = sval_r;
        oflg_nxt = sflg_r;
        sv_nxt   = 1'b0;
      end
    end else if (emit && ov_r && !pop) begin
      sval_nxt = res_val;
      sflg_nxt = res_flg;
      sv_nxt   = 1'b1;
    end else if (emit) begin
      oval_nxt = res_val;
      oflg_nxt = res_flg;
      ov_nxt   = 1'b1;
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      acc_r   <= '0;
      nacc_r  <= '0;
      sacc_r  <= '0;
      minus_r <= 1'b0;
      first_r <= 1'b0;
      point_r <= 1'b0;
      dec_r   <= '0;
      kind_r  <= '0;
      ov_r    <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      nacc_r  <= nacc_nxt;
      sacc_r  <= sacc_nxt;
      minus_r <= minus_nxt;
      first_r <= first_nxt;
      point_r <= point_nxt;
      dec_r   <= dec_nxt;
      kind_r  <= kind_nxt;
      ov_r    <= ov_nxt;
      sv_r    <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oval_r <= oval_nxt;
    oflg_r <= oflg_nxt;
    sval_r <= sval_nxt;
    sflg_r <= sflg_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = oval_r;
  assign out_tuser  = oflg_r;

endmodule

// File: design/anfp_checker.sv
// port-level checker for the ascii numeric field parser, bound to the top level
module anfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a waiting input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=>
      in_tvalid && $stable(in_tdata) && $stable(in_tuser) && $stable(in_tlast))
    else $error("input beat changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("bad character and decimals flag together");

  // a flagged result carries a zero value
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |-> out_tdata == 64'd0)
    else $error("flagged result with nonzero value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind ascii_numeric_field_parser anfp_checker u_anfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: verif/ascii_numeric_field_parser_tb.sv
// testbench for ascii_numeric_field_parser: random text messages checked against a field predictor
`timescale 1ns / 1ps

module ascii_numeric_field_parser_tb;
  import anfp_pkg::*;

  class field_scoreboard;
    typedef struct packed {
      logic [63:0] value;
      logic        bad;
      logic        dec_over;
    } field_result_t;

    localparam int DECIMALS = PRICE_DECIMALS_DEF;

    field_result_t expected_fields[$];
    logic [63:0]   acc;
    phase_t        ph;
    kind_t         held;
    logic          minus;
    logic          first_taken;
    logic          point;
    int            decimals;
    int            errors;
    int            bytes_taken;
    int            fields_checked;
    int            bad_fields;
    int            overrun_fields;

    function new();
      ph = PH_SKIP;
      held = KIND_UNSIGNED;
      clear_field();
    endfunction

    function void clear_field();
      acc = '0;
      minus = 1'b0;
      first_taken = 1'b0;
      point = 1'b0;
      decimals = 0;
    endfunction

    function bit is_separator(logic [7:0] c);
      return c inside {CH_SPACE, CH_BAR, CH_TAB, CH_LF, CH_HASH};
    endfunction

    // field ends: apply sign or price scaling and queue the value
    function void close_field();
      logic [63:0] v;
      logic        dec;
      v = acc;
      dec = 1'b0;
      if (held == KIND_SIGNED) begin
        if (minus) v = 64'd0 - v;
      end else if (held == KIND_PRICE) begin
        if (decimals > DECIMALS) begin
          v = '0;
          dec = 1'b1;
        end else begin
          for (int i = decimals; i < DECIMALS; i++) v = v * 64'd10;
        end
      end
      expected_fields.push_back('{value: v, bad: 1'b0, dec_over: dec});
      clear_field();
      ph = PH_SKIP;
    endfunction

    function void note_byte(logic [7:0] c, logic [1:0] k, logic eom);
      logic first;
      bytes_taken++;
      if (ph == PH_DISCARD) begin
        if (is_separator(c) || eom) begin
          clear_field();
          ph = PH_SKIP;
        end
        return;
      end
      if (ph != PH_ACC) begin
        if (c == CH_SPACE) begin
          // a message that ends on a space still yields an empty field
          if (eom) begin
            held = kind_t'(k);
            clear_field();
            close_field();
          end
          return;
        end
        held = kind_t'(k);
        clear_field();
        ph = PH_ACC;
      end
      if (is_separator(c)) begin
        close_field();
        return;
      end
      first = !first_taken;
      first_taken = 1'b1;
      if (held == KIND_SIGNED && first && c == CH_MINUS) begin
        minus = 1'b1;
      end else if (held == KIND_PRICE && c == CH_POINT && !point) begin
        point = 1'b1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        acc = acc * 64'd10 + 64'(c - CH_ZERO);
        if (held == KIND_PRICE && point && decimals <= DECIMALS) decimals++;
      end else begin
        expected_fields.push_back('{value: 64'd0, bad: 1'b1, dec_over: 1'b0});
        clear_field();
        ph = eom ? PH_SKIP : PH_DISCARD;
        return;
      end
      if (eom) close_field();
    endfunction

    function void check_result(logic [63:0] v, logic [1:0] flags);
      field_result_t exp_f;
      if (expected_fields.size() == 0) begin
        $error("unexpected result beat: field_value %0h flags %b", v, flags);
        errors++;
        return;
      end
      exp_f = expected_fields.pop_front();
      fields_checked++;
      if (exp_f.bad) bad_fields++;
      if (exp_f.dec_over) overrun_fields++;
      if (v !== exp_f.value) begin
        $error("field_value: expected %0h, got %0h", exp_f.value, v);
        errors++;
      end
      if (flags[0] !== exp_f.bad) begin
        $error("bad_character: expected %b, got %b", exp_f.bad, flags[0]);
        errors++;
      end
      if (flags[1] !== exp_f.dec_over) begin
        $error("decimals_exceeded: expected %b, got %b", exp_f.dec_over, flags[1]);
        errors++;
      end
    endfunction
  endclass

  localparam logic [7:0] SEPARATORS [5] = '{CH_SPACE, CH_BAR, CH_TAB, CH_LF, CH_HASH};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic [1:0]  in_tuser = '0;   // [1:0] kind
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] field_value
  logic [1:0]  out_tuser;       // [0] bad_character, [1] decimals_exceeded

  int send_idle = 0;
  int recv_idle = 0;

  field_scoreboard sb = new();

  ascii_numeric_field_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic send_byte(input logic [7:0] c, input logic [1:0] k, input logic eom);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= k;
    in_tlast <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(c, k, eom);
  endtask

  task automatic send_text(input string s, input logic [1:0] k, input logic ends_message);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], k, ends_message && (i == s.len() - 1));
  endtask

  // hold the input side quiet until every queued field has come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_fields.size() != 0) @(negedge clk);
  endtask

  // one message: mostly well-formed fields, some corrupted bytes, some pure noise
  task automatic send_message();
    logic [9:0] txt[$];
    logic [1:0] k;
    kind_t      fk;
    int         nfields;
    int         len;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) txt.push_back(10'($urandom_range(1023)));
    end else begin
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
        fk = kind_t'($urandom_range(3));
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) txt.push_back({fk, CH_SPACE});
        if (fk == KIND_SIGNED && $urandom_range(1)) txt.push_back({fk, CH_MINUS});
        // long digit runs can wrap the 64-bit accumulator
        len = ($urandom_range(9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 6);
        repeat (len) txt.push_back({fk, 8'(CH_ZERO + $urandom_range(9))});
        if (fk == KIND_PRICE && $urandom_range(3) != 0) begin
          txt.push_back({fk, CH_POINT});
          repeat ($urandom_range(0, 6)) txt.push_back({fk, 8'(CH_ZERO + $urandom_range(9))});
        end
        if (f < nfields - 1 || $urandom_range(1)) txt.push_back({fk, SEPARATORS[$urandom_range(4)]});
      end
      if (txt.size() == 0) txt.push_back({KIND_UNSIGNED, CH_SPACE});
      foreach (txt[i]) begin
        if ($urandom_range(19) == 0) txt[i] = {txt[i][9:8], 8'($urandom_range(255))};
      end
    end
    foreach (txt[i]) begin
      // kind on bytes past the first of each field is ignored, so scramble it now and then
      k = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : txt[i][9:8];
      send_byte(txt[i][7:0], k, i == txt.size() - 1);
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int n_bytes);
    int target;
    send_idle = s_idle;
    recv_idle = r_idle;
    target = sb.bytes_taken + n_bytes;
    while (sb.bytes_taken < target) begin
      send_message();
      if ($urandom_range(39) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle = 36;
    recv_idle = 84;
    send_text("  7|", KIND_UNSIGNED, 1'b0);
    send_text("-5\t", KIND_SIGNED, 1'b0);
    send_text("1.5 ", KIND_PRICE, 1'b0);
    send_text(".12345\n", KIND_PRICE, 1'b0);
    send_byte(8'hff, KIND_UNSIGNED, 1'b0);
    send_text("9|", KIND_UNSIGNED, 1'b0);
    send_text("9", KIND_UNUSED, 1'b1);
    send_text("#", KIND_UNSIGNED, 1'b0);
    send_text(" ", KIND_SIGNED, 1'b1);
    send_text("-", KIND_SIGNED, 1'b1);
    send_text(".", KIND_PRICE, 1'b1);
    drain_results();

    run_phase(36, 84, 350);
    run_phase(84, 36, 350);
    run_phase(0, 0, 350);

    recv_idle = 0;
    drain_results();
    // any stray beat after the last field is flagged by the scoreboard
    repeat (20) @(negedge clk);

    $display("covered %0d message bytes over three idle patterns", sb.bytes_taken);
    $display("checked %0d fields: %0d with a bad character, %0d with too many decimals",
             sb.fields_checked, sb.bad_fields, sb.overrun_fields);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
